@@ hdl/wpf3d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wpf3d_pkg
// Types and constants shared by the waypoint path follower.
// -----------------------------------------------------------------------------
package wpf3d_pkg;

    localparam int MaxWaypoints = 16;
    localparam int IdxW         = $clog2(MaxWaypoints);
    localparam int CntW         = $clog2(MaxWaypoints + 1);
    localparam int RateW        = 10;
    localparam logic [RateW-1:0] RateMin   = 10'd1;
    localparam logic [RateW-1:0] RateMax   = 10'd1000;
    localparam logic [RateW-1:0] RateReset = 10'd30;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SETPOS = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
        logic signed [31:0] speed;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [4:0]         waypoints_left;
        logic               arrived;
        logic               overflow;
    } out_word_t;

endpackage
`default_nettype wire

@@ hdl/waypoint_path_follower_3d.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// waypoint_path_follower_3d
// Moves a point in three dimensions along a queue of up to sixteen waypoints.
//
// Input words (s_) carry a command and its operands; every accepted word gives
// exactly one result word (m_) with the position and queue state after it.
// The tick rate register is written on its own cfg channel; the user must
// write it only while idle, as the block itself does not enforce this.
// Append, set position, clear and a tick that does not move go from the
// decode state straight to the output state.
// A moving tick runs the speed divide, a square root of the summed squares
// and the three axis divides; when a waypoint is dropped the distance and
// root are worked anew, and when the point snaps onto a waypoint the axis
// divides are skipped. The bit-serial divider and root unit give one result
// bit per cycle. One word is worked on at a time; the next can be taken in
// the cycle after the result is accepted. While the receiver stalls, the
// result sits in the output register and no further word is taken.
// Reset clears the queue, sets the position to the origin and the rate to 30.
// The waypoint store is not cleared; only written entries are ever read.
// -----------------------------------------------------------------------------
module waypoint_path_follower_3d
    import wpf3d_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_word_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_word_t       m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [RateW-1:0] cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_DECO  = 10'b0000000010,
        ST_SDIV  = 10'b0000000100,
        ST_LOAD  = 10'b0000001000,
        ST_DIFF  = 10'b0000010000,
        ST_SQ    = 10'b0000100000,
        ST_ROOT  = 10'b0001000000,
        ST_DECI  = 10'b0010000000,
        ST_AXDIV = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [RateW-1:0]   rate_reg;
    logic [IdxW-1:0]    head_reg;
    logic [CntW-1:0]    count_reg;
    logic signed [31:0] pos_reg [3];
    logic [95:0]        store [MaxWaypoints];
    logic [95:0]        front_reg;
    in_word_t           in_reg;
    out_word_t          out_reg;
    logic               m_valid_reg;
    logic               arrived_reg, overflow_reg;
    logic               dropped_reg;

    // Shared bit-serial unit: restoring divide or square root.
    logic [65:0]        num_reg;
    logic [65:0]        rem_reg;
    logic [65:0]        quo_reg;
    logic [65:0]        den_reg;
    logic [6:0]         bit_reg;
    logic [33:0]        step_reg;
    logic signed [33:0] diff_reg [3];
    logic [1:0]         axis_reg;
    logic [65:0]        sum_reg;

    logic [RateW-1:0]   rate_c;
    logic [66:0]        trial;
    logic [66:0]        rem_sh;
    logic [65:0]        root_tr;
    logic [1:0]         axis_sel;
    logic [33:0]        mag_a;
    logic [67:0]        sq_a;
    logic [67:0]        prod_a;
    logic signed [34:0] newc;
    logic [33:0]        q_sat;
    logic signed [34:0] delta;
    logic [IdxW-1:0]    wr_idx;

    assign rate_c    = (rate_reg < RateMin) ? RateMin :
                       (rate_reg > RateMax) ? RateMax : rate_reg;
    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign wr_idx    = head_reg + count_reg[IdxW-1:0];

    // Divide: shift one numerator bit in; root: two bits in, trial 4r+1.
    assign rem_sh  = {rem_reg, num_reg[65]};
    assign trial   = rem_sh - {1'b0, den_reg};
    assign root_tr = {rem_reg[63:0], num_reg[65:64]};

    assign axis_sel = (state_reg == ST_AXDIV && bit_reg == 7'd0 && axis_reg != 2'd2) ?
                      axis_reg + 2'd1 : axis_reg;
    assign mag_a   = diff_reg[axis_sel][33] ? 34'(-diff_reg[axis_sel])
                                            : 34'(diff_reg[axis_sel]);
    assign sq_a    = mag_a * mag_a;
    assign prod_a  = mag_a * step_reg;
    assign q_sat   = (quo_reg > 66'h2_0000_0000) ? 34'h2_0000_0000 : quo_reg[33:0];
    assign delta   = diff_reg[axis_reg][33] ? -$signed({1'b0, q_sat})
                                            : $signed({1'b0, q_sat});
    assign newc    = 35'(pos_reg[axis_reg]) + delta;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_data.command == CMD_APPEND
            && count_reg < CntW'(MaxWaypoints)) begin
            store[wr_idx] <= {s_data.x_coord, s_data.y_coord, s_data.z_coord};
        end
        if (state_reg == ST_LOAD) begin
            front_reg <= store[head_reg];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid && s_ready) state_next = ST_DECO;
            ST_DECO: begin
                if (in_reg.command == CMD_TICK && in_reg.speed > 0 && count_reg != 0) begin
                    state_next = ST_SDIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SDIV:  if (bit_reg == 7'd0) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_SQ;
            ST_SQ:    if (axis_reg == 2'd2) state_next = ST_ROOT;
            ST_ROOT:  if (bit_reg == 7'd0) state_next = ST_DECI;
            ST_DECI:  state_next = ST_AXDIV;
            ST_AXDIV: if (bit_reg == 7'd0 && axis_reg == 2'd2) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
        if (state_reg == ST_DECI) begin
            if ({31'd0, quo_reg[34:0]} < {32'd0, step_reg} && !dropped_reg) begin
                if (count_reg == CntW'(1)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_LOAD;
                end
            end else if (quo_reg[34:0] == '0) begin
                state_next = ST_OUT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rate_reg    <= RateReset;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                rate_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        in_reg       <= s_data;
                        arrived_reg  <= 1'b0;
                        overflow_reg <= 1'b0;
                        dropped_reg  <= 1'b0;
                        if (s_data.command == CMD_APPEND) begin
                            if (count_reg >= CntW'(MaxWaypoints)) begin
                                overflow_reg <= 1'b1;
                            end else begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_DECO: begin
                    unique case (cmd_t'(in_reg.command))
                        CMD_SETPOS: begin
                            pos_reg[0] <= in_reg.x_coord;
                            pos_reg[1] <= in_reg.y_coord;
                            pos_reg[2] <= in_reg.z_coord;
                        end
                        CMD_CLEAR: begin
                            count_reg <= '0;
                            head_reg  <= '0;
                        end
                        default: ;
                    endcase
                    num_reg <= {in_reg.speed, 34'd0};
                    rem_reg <= '0;
                    quo_reg <= '0;
                    den_reg <= 66'(rate_c);
                    bit_reg <= 7'd31;
                end
                ST_SDIV: begin
                    if (!trial[66]) begin
                        rem_reg <= trial[65:0];
                    end else begin
                        rem_reg <= rem_sh[65:0];
                    end
                    quo_reg <= {quo_reg[64:0], !trial[66]};
                    num_reg <= {num_reg[64:0], 1'b0};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == 7'd0) begin
                        step_reg <= {quo_reg[32:0], !trial[66]};
                    end
                end
                ST_LOAD: ;
                ST_DIFF: begin
                    diff_reg[0] <= 34'($signed(front_reg[95:64])) - 34'(pos_reg[0]);
                    diff_reg[1] <= 34'($signed(front_reg[63:32])) - 34'(pos_reg[1]);
                    diff_reg[2] <= 34'($signed(front_reg[31:0]))  - 34'(pos_reg[2]);
                    axis_reg    <= 2'd0;
                    sum_reg     <= '0;
                end
                ST_SQ: begin
                    sum_reg <= sum_reg + sq_a[65:0];
                    if (axis_reg == 2'd2) begin
                        num_reg  <= sum_reg + sq_a[65:0];
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        bit_reg  <= 7'd32;
                        axis_reg <= 2'd0;
                    end else begin
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                ST_ROOT: begin
                    if (root_tr >= {quo_reg[63:0], 2'b01}) begin
                        rem_reg <= root_tr - {quo_reg[63:0], 2'b01};
                        quo_reg <= {quo_reg[64:0], 1'b1};
                    end else begin
                        rem_reg <= root_tr;
                        quo_reg <= {quo_reg[64:0], 1'b0};
                    end
                    num_reg <= {num_reg[63:0], 2'b00};
                    bit_reg <= bit_reg - 1'b1;
                end
                ST_DECI: begin
                    if ({31'd0, quo_reg[34:0]} < {32'd0, step_reg} && !dropped_reg) begin
                        if (count_reg == CntW'(1)) begin
                            pos_reg[0]  <= $signed(front_reg[95:64]);
                            pos_reg[1]  <= $signed(front_reg[63:32]);
                            pos_reg[2]  <= $signed(front_reg[31:0]);
                            count_reg   <= '0;
                            head_reg    <= '0;
                            arrived_reg <= 1'b1;
                        end else begin
                            head_reg    <= head_reg + 1'b1;
                            count_reg   <= count_reg - 1'b1;
                            dropped_reg <= 1'b1;
                        end
                    end else if (quo_reg[34:0] == '0) begin
                        pos_reg[0] <= $signed(front_reg[95:64]);
                        pos_reg[1] <= $signed(front_reg[63:32]);
                        pos_reg[2] <= $signed(front_reg[31:0]);
                    end
                    num_reg  <= prod_a[65:0];
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    den_reg  <= 66'(quo_reg[34:0]);
                    bit_reg  <= 7'd66;
                    axis_reg <= 2'd0;
                end
                ST_AXDIV: begin
                    if (bit_reg == 7'd0) begin
                        pos_reg[axis_reg] <=
                            (newc > 35'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                            (newc < -35'sh0_8000_0000) ? 32'sh8000_0000 : newc[31:0];
                        axis_reg <= axis_reg + 1'b1;
                        num_reg  <= prod_a[65:0];
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        bit_reg  <= 7'd66;
                    end else begin
                        if (!trial[66]) begin
                            rem_reg <= trial[65:0];
                        end else begin
                            rem_reg <= rem_sh[65:0];
                        end
                        quo_reg <= {quo_reg[64:0], !trial[66]};
                        num_reg <= {num_reg[64:0], 1'b0};
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                ST_OUT: begin
                    out_reg.pos_x          <= pos_reg[0];
                    out_reg.pos_y          <= pos_reg[1];
                    out_reg.pos_z          <= pos_reg[2];
                    out_reg.waypoints_left <= 5'(count_reg);
                    out_reg.arrived        <= arrived_reg;
                    out_reg.overflow       <= overflow_reg;
                    m_valid_reg            <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hdl/wpf3d_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wpf3d_checker
// Port-level checks on the waypoint path follower.
// -----------------------------------------------------------------------------
module wpf3d_checker
    import wpf3d_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result word changed");

    a_no_take_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.waypoints_left <= 5'd16) else $error("queue count out of range");

    a_arrive_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.arrived |-> m_data.waypoints_left == 5'd0 && !m_data.overflow)
        else $error("arrival with queue left");

endmodule

bind waypoint_path_follower_3d wpf3d_checker u_wpf3d_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the waypoint path follower. Words are sent through
// the input channel with random gaps, a predictor follows the point and the
// waypoint ring, and each result word is compared with the oldest prediction.
// -----------------------------------------------------------------------------
module tb;
    import wpf3d_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [RateW-1:0] cfg_data;

    waypoint_path_follower_3d u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    logic signed [63:0] ring_pt [MaxWaypoints][3];
    logic signed [63:0] here [3];
    int unsigned        head_idx;
    int unsigned        queued;
    logic [RateW-1:0]   rate_reg;

    out_word_t  pending_pos [$];
    int         mismatches;
    longint     cycles;
    bit         idle_on;
    bit         hold_long;
    int         hold_left;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 64'd3000000) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    function automatic logic [63:0] root66(logic [65:0] v);
        logic [65:0] r;
        logic [65:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (66'd1 << b);
            if (132'(c) * 132'(c) <= 132'(v)) begin
                r = c;
            end
        end
        return r[63:0];
    endfunction

    function automatic logic [63:0] span_to(int unsigned k);
        logic [65:0] acc;
        logic [63:0] m;
        logic signed [63:0] d;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            d = ring_pt[k][i] - here[i];
            m = d < 0 ? -d : d;
            acc += 66'(m) * 66'(m);
        end
        return root66(acc);
    endfunction

    function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void step_toward(int unsigned k, logic [63:0] stp, logic [63:0] dst);
        logic signed [63:0] d;
        logic [127:0] q;
        for (int i = 0; i < 3; i++) begin
            d = ring_pt[k][i] - here[i];
            q = 128'(d < 0 ? -d : d) * 128'(stp) / 128'(dst);
            if (q > (128'd1 << 33)) begin
                q = 128'd1 << 33;
            end
            here[i] = clamp32(here[i] + (d < 0 ? -$signed(q[63:0]) : $signed(q[63:0])));
        end
    endfunction

    function automatic bit advance_point(logic signed [31:0] spd);
        int unsigned r;
        logic [63:0] stp;
        logic [63:0] dst;
        if (spd <= 0 || queued == 0) begin
            return 1'b0;
        end
        r = rate_reg;
        if (r < 1) begin
            r = 1;
        end
        if (r > 1000) begin
            r = 1000;
        end
        stp = 64'(spd) / r;
        dst = span_to(head_idx);
        if (dst < stp) begin
            if (queued == 1) begin
                for (int i = 0; i < 3; i++) begin
                    here[i] = ring_pt[head_idx][i];
                end
                queued = 0;
                head_idx = 0;
                return 1'b1;
            end
            head_idx = (head_idx + 1) % MaxWaypoints;
            queued--;
            dst = span_to(head_idx);
        end
        if (dst == 0) begin
            for (int i = 0; i < 3; i++) begin
                here[i] = ring_pt[head_idx][i];
            end
        end else begin
            step_toward(head_idx, stp, dst);
        end
        return 1'b0;
    endfunction

    function automatic out_word_t predict_position(in_word_t w);
        out_word_t o;
        o = '0;
        case (cmd_t'(w.command))
            CMD_TICK: begin
                o.arrived = advance_point(w.speed);
            end
            CMD_APPEND: begin
                if (queued >= MaxWaypoints) begin
                    o.overflow = 1'b1;
                end else begin
                    ring_pt[(head_idx + queued) % MaxWaypoints][0] = w.x_coord;
                    ring_pt[(head_idx + queued) % MaxWaypoints][1] = w.y_coord;
                    ring_pt[(head_idx + queued) % MaxWaypoints][2] = w.z_coord;
                    queued++;
                end
            end
            CMD_SETPOS: begin
                here[0] = w.x_coord;
                here[1] = w.y_coord;
                here[2] = w.z_coord;
            end
            default: begin
                queued = 0;
                head_idx = 0;
            end
        endcase
        o.pos_x = here[0][31:0];
        o.pos_y = here[1][31:0];
        o.pos_z = here[2][31:0];
        o.waypoints_left = 5'(queued);
        return o;
    endfunction

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic send_word(cmd_t c, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic signed [31:0] spd);
        in_word_t w;
        w.command = c;
        w.x_coord = x;
        w.y_coord = y;
        w.z_coord = z;
        w.speed = spd;
        idle_gap();
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        pending_pos = {pending_pos, predict_position(w)};
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_then_write(logic [RateW-1:0] r);
        while (pending_pos.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= r;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_reg = r;
    endtask

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            2: return 32'sh7fff_ffff - $urandom_range(0, 3);
            3: return 32'sh8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_speed();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return -$signed($urandom_range(0, 1000));
            2: return 32'sh7fff_ffff;
            default: return $urandom_range(1, 32'h0fff_ffff);
        endcase
    endfunction

    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_pos.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected word %p", m_data);
                    end
                end else if (m_data !== pending_pos[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %p got %p", pending_pos[0], m_data);
                    end
                    void'(pending_pos.pop_front());
                end else begin
                    void'(pending_pos.pop_front());
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                m_ready <= 1'b0;
                hold_left = 400;
                while (hold_left > 0) begin
                    @(posedge aclk);
                    hold_left--;
                end
                hold_long = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_word(CMD_TICK, 0, 0, 0, 32'sd65536);
        send_word(CMD_APPEND, 32'sh0010_0000, 0, 0, 0);
        send_word(CMD_TICK, 0, 0, 0, -32'sd5);
        send_word(CMD_TICK, 0, 0, 0, 0);
        send_word(CMD_TICK, 0, 0, 0, 32'sd3000000);
        send_word(CMD_TICK, 0, 0, 0, 32'sh7fff_ffff);
        send_word(CMD_SETPOS, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0);
        send_word(CMD_APPEND, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        send_word(CMD_APPEND, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0);
        send_word(CMD_TICK, 0, 0, 0, 32'sh7fff_ffff);
        send_word(CMD_TICK, 0, 0, 0, 32'sh7fff_ffff);
        send_word(CMD_CLEAR, 32'sh1234, 0, 0, 32'sh5);
        send_word(CMD_SETPOS, 0, 0, 0, 0);
        send_word(CMD_APPEND, 0, 0, 0, 0);
        send_word(CMD_APPEND, 32'sd30, 0, 0, 0);
        send_word(CMD_TICK, 0, 0, 0, 32'sd900);
        for (int i = 0; i < 17; i++) begin
            send_word(CMD_APPEND, i * 32'sh10000, -i, i, 0);
        end
        send_word(CMD_CLEAR, 0, 0, 0, 0);
    endtask

    task automatic test_random(int n);
        int c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 19);
            if (c < 9) begin
                send_word(CMD_TICK, $urandom(), $urandom(), $urandom(), rnd_speed());
            end else if (c < 15) begin
                send_word(CMD_APPEND, rnd_coord(), rnd_coord(), rnd_coord(), $urandom());
            end else if (c < 18) begin
                send_word(CMD_SETPOS, rnd_coord(), rnd_coord(), rnd_coord(), $urandom());
            end else begin
                send_word(CMD_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
            end
        end
    endtask

    task automatic test_backpressure();
        hold_long = 1'b1;
        test_random(12);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        idle_on = 1'b1;
        hold_long = 1'b0;
        head_idx = 0;
        queued = 0;
        rate_reg = RateReset;
        for (int i = 0; i < 3; i++) begin
            here[i] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(300);
        drain_then_write(10'd1);
        test_directed();
        test_random(300);
        drain_then_write(10'd1000);
        test_random(250);
        drain_then_write(10'd0);
        test_random(200);
        drain_then_write(10'd1023);
        test_backpressure();
        test_random(200);
        drain_then_write(10'd7);
        idle_on = 1'b0;
        test_random(200);
        while (pending_pos.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
